// File: rtl/core/wide_integer_alu_256_top_assert.svh
// ----------------------------------------------------------------------------
// wide integer alu assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef WIDE_INTEGER_ALU_256_TOP_ASSERT_SVH
`define WIDE_INTEGER_ALU_256_TOP_ASSERT_SVH

// implication checked outside reset
`define WIA_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication checked also during reset
`define WIA_ASSERT_NEXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// File: rtl/core/wia256_pkg.sv
// ----------------------------------------------------------------------------
// wia256_pkg
// types and constants of the 256-bit integer alu
// ----------------------------------------------------------------------------
package wia256_pkg;

   localparam int unsigned WordBits  = 64;
   localparam int unsigned Words     = 4;
   localparam int unsigned TotalBits = WordBits * Words;
   localparam int unsigned DigitBits = 32;
   localparam int unsigned Digits    = TotalBits / DigitBits;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_SHL = 2'd3
   } command_type;

   typedef struct packed {
      command_type         command;
      logic [63:0]         a_word0;
      logic [63:0]         a_word1;
      logic [63:0]         a_word2;
      logic [63:0]         a_word3;
      logic [63:0]         b_word0;
      logic [63:0]         b_word1;
      logic [63:0]         b_word2;
      logic [63:0]         b_word3;
      logic [7:0]          shift_amount;
   } req_type;

   typedef struct packed {
      logic [63:0] r_word0;
      logic [63:0] r_word1;
      logic [63:0] r_word2;
      logic [63:0] r_word3;
   } rsp_type;

endpackage

// File: rtl/core/wide_integer_alu_256_top.sv
// ----------------------------------------------------------------------------
// wide_integer_alu_256_top
// 256-bit unsigned add, subtract, multiply and left shift
// ----------------------------------------------------------------------------
// Six-stage pipeline, one item per cycle while the rsp side takes results. An
// accepted item passes stages 1 to 6 in order; rsp_valid is the valid flag of stage 6.
// Stage 1 registers the operands, stage 2 forms 36 registered
// 32x32 partial products and the add, subtract or shift result, stages 3 to 6
// reduce the products with a tree of 256-bit adders. Results wrap modulo
// 2^256. Each stage holds its item while the next stage is full and stalled, so
// bubbles close up and a stalled rsp side backs up without loss.
module wide_integer_alu_256_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wia256_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wia256_pkg::rsp_type rsp_data
);
   import wia256_pkg::*;

   localparam int unsigned Stages = 6;

   logic [Stages:1] valid_ff;
   logic [Stages+1:1] en;

   command_type cmd1_ff, cmd2_ff, cmd3_ff, cmd4_ff, cmd5_ff;
   logic [TotalBits-1:0] a1_ff, b1_ff;
   logic [7:0] sh1_ff;
   logic [TotalBits-1:0] alu2_ff, alu3_ff, alu4_ff, alu5_ff;
   logic [TotalBits-1:0] alu2_in;
   logic [Digits-1:0][Digits-1:0][2*DigitBits-1:0] pp2_ff;
   logic [Digits-1:0][TotalBits-1:0] row3_ff, row3_in;
   logic [3:0][TotalBits-1:0] sum4_ff;
   logic [1:0][TotalBits-1:0] sum5_ff;
   logic [TotalBits-1:0] r6_ff, r6_in;

   always_comb begin
      en[Stages+1] = rsp_ready;
      for (int k = Stages; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= Stages; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      case (cmd1_ff)
         CMD_ADD: alu2_in = a1_ff + b1_ff;
         CMD_SUB: alu2_in = a1_ff + ~b1_ff + TotalBits'(1);
         CMD_SHL: alu2_in = a1_ff << sh1_ff;
         default: alu2_in = '0;
      endcase
   end

   always_comb begin
      logic [TotalBits-1:0] ev, od;
      for (int i = 0; i < Digits; i++) begin
         ev = '0;
         od = '0;
         for (int j = 0; j < Digits; j++) begin
            if (i + j < Digits) begin
               if (j % 2 == 0) begin
                  ev = ev | (TotalBits'(pp2_ff[i][j]) << (DigitBits * (i + j)));
               end else begin
                  od = od | (TotalBits'(pp2_ff[i][j]) << (DigitBits * (i + j)));
               end
            end
         end
         row3_in[i] = ev + od;
      end
   end

   always_comb begin
      if (cmd5_ff == CMD_MUL) begin
         r6_in = sum5_ff[0] + sum5_ff[1];
      end else begin
         r6_in = alu5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cmd1_ff <= req_data.command;
         a1_ff   <= {req_data.a_word3, req_data.a_word2, req_data.a_word1, req_data.a_word0};
         b1_ff   <= {req_data.b_word3, req_data.b_word2, req_data.b_word1, req_data.b_word0};
         sh1_ff  <= req_data.shift_amount;
      end
      if (en[2]) begin
         cmd2_ff <= cmd1_ff;
         alu2_ff <= alu2_in;
         for (int i = 0; i < Digits; i++) begin
            for (int j = 0; j < Digits; j++) begin
               if (i + j < Digits) begin
                  pp2_ff[i][j] <= a1_ff[DigitBits*i +: DigitBits]
                                  * b1_ff[DigitBits*j +: DigitBits];
               end else begin
                  pp2_ff[i][j] <= '0;
               end
            end
         end
      end
      if (en[3]) begin
         cmd3_ff <= cmd2_ff;
         alu3_ff <= alu2_ff;
         row3_ff <= row3_in;
      end
      if (en[4]) begin
         cmd4_ff <= cmd3_ff;
         alu4_ff <= alu3_ff;
         for (int k = 0; k < 4; k++) begin
            sum4_ff[k] <= row3_ff[2*k] + row3_ff[2*k+1];
         end
      end
      if (en[5]) begin
         cmd5_ff <= cmd4_ff;
         alu5_ff <= alu4_ff;
         for (int k = 0; k < 2; k++) begin
            sum5_ff[k] <= sum4_ff[2*k] + sum4_ff[2*k+1];
         end
      end
      if (en[6]) begin
         r6_ff <= r6_in;
      end
   end

   assign rsp_valid        = valid_ff[Stages];
   assign rsp_data.r_word0 = r6_ff[63:0];
   assign rsp_data.r_word1 = r6_ff[127:64];
   assign rsp_data.r_word2 = r6_ff[191:128];
   assign rsp_data.r_word3 = r6_ff[255:192];

endmodule

// File: rtl/core/wia256_checker.sv
// ----------------------------------------------------------------------------
// wia256_checker
// port-level checks of the 256-bit integer alu, bound to the top level
// ----------------------------------------------------------------------------
`include "wide_integer_alu_256_top_assert.svh"

module wia256_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input wia256_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wia256_pkg::rsp_type rsp_data
);
   import wia256_pkg::*;

   // stalled result item holds
   `WIA_ASSERT_NEXT(rsp_hold_chk, clock, !reset && rsp_valid && !rsp_ready, reset || (rsp_valid && $stable(rsp_data)))

   // stalled input item holds
   `WIA_ASSERT_NEXT(req_hold_chk, clock, !reset && req_valid && !req_ready, reset || (req_valid && $stable(req_data)))

   // pipeline is empty after reset
   `WIA_ASSERT_NEXT(rsp_reset_chk, clock, reset, !rsp_valid)

   // with nothing waiting at the output the pipeline always takes an item
   `WIA_ASSERT_IMPL(req_free_chk, clock, reset, !rsp_valid, req_ready)

   // a draining output never blocks the input
   `WIA_ASSERT_IMPL(req_flow_chk, clock, reset, rsp_ready, req_ready)

endmodule

bind wide_integer_alu_256_top wia256_checker u_wia256_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
